// ----- hw/rtl/ulir_pkg.sv -----
// ----------------------------------------------------------------------------
// ulir_pkg: shared types and constants of the linear interpolation resampler
// Payload structs, configuration register codes, controller commands and
// status, and the sizes that the datapath and the controller both follow.
// ----------------------------------------------------------------------------
package ulir_pkg;

  localparam int LANES    = 4;
  localparam int MAX_RUN  = 64;
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int RUN_W    = $clog2(MAX_RUN + 1);
  localparam int MAG_W    = 33;
  localparam int PROD_W   = 65;
  localparam int MD_CNT_W = 7;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [31:0] STEP_RESET  = 32'h0001_0000;
  localparam logic [15:0] COUNT_RESET = 16'd1;

  typedef enum logic {
    REG_SAMPLE_STEP  = 1'b0,
    REG_SAMPLE_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        knot_time;
    logic signed [31:0] pos_a;
    logic signed [31:0] pos_b;
    logic signed [31:0] pos_c;
    logic signed [31:0] pos_d;
    logic               start_req;
  } in_t;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;
    logic signed [31:0] val_d;
    logic               run_end;
    logic               truncated;
    logic               all_done;
  } out_t;

  typedef enum logic [1:0] {
    MD_RATIO,
    MD_INIT,
    MD_STEP
  } md_op_t;

  typedef logic [LANE_W-1:0] lane_t;

  typedef struct packed {
    logic   start_apply;
    logic   commit;
    logic   avail_rem;
    logic   md_start;
    logic   md_store;
    md_op_t md_op;
    lane_t  lane;
    logic   setup;
    logic   latch_out;
    logic   advance;
    logic   incr;
  } cmd_t;

  typedef struct packed {
    logic knot_start;
    logic started;
    logic no_avail;
    logic step_zero;
    logic md_done;
    logic d_zero;
    logic last;
  } sts_t;

endpackage

// ----- hw/rtl/ulir_muldiv.sv -----
// ----------------------------------------------------------------------------
// ulir_muldiv: sequential multiply then divide
// Computes floor(a * b / c) and its remainder: a shift-add multiply of one
// bit per cycle, then a restoring division of one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ulir_muldiv
  import ulir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  a,
  input  logic [31:0]       b,
  input  logic [31:0]       c,
  output logic              done,
  output logic [PROD_W-1:0] quot,
  output logic [31:0]       remd
);

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV} phase_t;

  localparam logic [MD_CNT_W-1:0] MUL_LAST = MD_CNT_W'(MUL_STEPS - 1);
  localparam logic [MD_CNT_W-1:0] DIV_LAST = MD_CNT_W'(DIV_STEPS - 1);

  phase_t              phase;
  logic [MD_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mcand;
  logic [31:0]         mplier;
  logic [31:0]         divisor;
  logic [32:0]         part;
  logic [32:0]         trial;
  logic                fits;

  // The product sits in acc; the division shifts it out at the top while
  // quotient bits enter at the bottom.
  assign trial = {part[31:0], acc[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            acc     <= '0;
            mcand   <= {{(PROD_W-MAG_W){1'b0}}, a};
            mplier  <= b;
            divisor <= c;
            cnt     <= '0;
            phase   <= P_MUL;
          end
        end
        P_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            part  <= '0;
            phase <= P_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        P_DIV: begin
          part <= fits ? (trial - {1'b0, divisor}) : trial;
          acc  <= {acc[PROD_W-2:0], fits};
          if (cnt == DIV_LAST) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign quot = acc;
  assign remd = part[31:0];

endmodule

// ----- hw/rtl/ulir_datapath.sv -----
// ----------------------------------------------------------------------------
// ulir_datapath: registers and arithmetic of the resampler
// Holds configuration, knot state and per-lane quotient accumulators, and
// forms each output sample on command of the controller.
// ----------------------------------------------------------------------------
module ulir_datapath
  import ulir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_accept,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  cfg_reg_t    cfg_index,
  input  logic [31:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_t        out_data
);

  logic [31:0]        sample_step;
  logic [15:0]        sample_count;
  logic [31:0]        prev_time;
  logic signed [31:0] prev_pos [LANES];
  logic [31:0]        next_instant;
  logic [15:0]        emitted;
  logic               started;

  logic [31:0]        knot_time;
  logic signed [31:0] knot_pos [LANES];
  logic               knot_start;

  logic [15:0]        avail;
  logic [RUN_W-1:0]   nemit;
  logic [RUN_W-1:0]   kcnt;
  logic               trunc;
  logic [15:0]        skip;
  logic [47:0]        skip_step;

  logic [MAG_W-1:0]   lq [LANES];
  logic [31:0]        lr [LANES];
  logic [MAG_W-1:0]   sq [LANES];
  logic [31:0]        sr [LANES];

  logic [MAG_W-1:0]   mag [LANES];
  logic               neg [LANES];
  logic [31:0]        span;
  logic [31:0]        elapsed;
  logic [15:0]        rem;
  logic               last;
  logic [16:0]        emitted_after;
  logic [48:0]        next_sum;

  logic               md_done;
  logic [MAG_W-1:0]   md_a;
  logic [31:0]        md_b;
  logic [31:0]        md_c;
  logic [PROD_W-1:0]  md_q;
  logic [31:0]        md_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [32:0] diff;
      diff   = {knot_pos[l][31], knot_pos[l]} - {prev_pos[l][31], prev_pos[l]};
      neg[l] = diff[32];
      mag[l] = diff[32] ? (~diff + 1'b1) : diff;
    end
  end

  assign span    = (knot_time > prev_time) ? (knot_time - prev_time) : 32'd0;
  assign elapsed = (next_instant > prev_time) ? (next_instant - prev_time) : 32'd0;
  assign rem     = (sample_count > emitted) ? (sample_count - emitted) : 16'd0;
  assign last    = (RUN_W'(kcnt + 1'b1) == nemit);

  assign emitted_after = {1'b0, emitted} + 17'd1 + ((last && trunc) ? {1'b0, skip} : 17'd0);
  assign next_sum = {17'd0, next_instant} + {17'd0, sample_step}
                  + ((last && trunc) ? {1'b0, skip_step} : 49'd0);

  always_comb begin
    case (cmd.md_op)
      MD_RATIO: begin
        md_a = {1'b0, knot_time - next_instant} + {1'b0, sample_step} - 33'd1;
        md_b = 32'd1;
        md_c = sample_step;
      end
      MD_INIT: begin
        md_a = mag[cmd.lane];
        md_b = elapsed;
        md_c = span;
      end
      MD_STEP: begin
        md_a = mag[cmd.lane];
        md_b = sample_step;
        md_c = span;
      end
      default: begin
        md_a = '0;
        md_b = '0;
        md_c = '0;
      end
    endcase
  end

  ulir_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .done  (md_done),
    .quot  (md_q),
    .remd  (md_r)
  );

  // Control state and the block state that the reset defines.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_step  <= STEP_RESET;
      sample_count <= COUNT_RESET;
      prev_time    <= '0;
      next_instant <= STEP_RESET;
      emitted      <= '0;
      started      <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        prev_pos[l] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_STEP:  sample_step  <= cfg_data;
          REG_SAMPLE_COUNT: sample_count <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.start_apply || cmd.commit) begin
        prev_time <= knot_time;
        for (int l = 0; l < LANES; l++) begin
          prev_pos[l] <= knot_pos[l];
        end
      end
      if (cmd.start_apply) begin
        next_instant <= sample_step;
        emitted      <= '0;
        started      <= 1'b1;
      end
      if (cmd.advance) begin
        emitted      <= emitted_after[15:0];
        next_instant <= (next_sum[48:32] != 17'd0) ? 32'hFFFF_FFFF : next_sum[31:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      knot_time   <= in_data.knot_time;
      knot_pos[0] <= in_data.pos_a;
      knot_pos[1] <= in_data.pos_b;
      knot_pos[2] <= in_data.pos_c;
      knot_pos[3] <= in_data.pos_d;
      knot_start  <= in_data.start_req;
    end
    if (cmd.avail_rem) begin
      avail <= rem;
    end
    if (cmd.md_store) begin
      case (cmd.md_op)
        MD_RATIO: avail <= (md_q < {49'd0, rem}) ? md_q[15:0] : rem;
        MD_INIT: begin
          lq[cmd.lane] <= md_q[MAG_W-1:0];
          lr[cmd.lane] <= md_r;
        end
        MD_STEP: begin
          sq[cmd.lane] <= md_q[MAG_W-1:0];
          sr[cmd.lane] <= md_r;
        end
        default: ;
      endcase
    end
    if (cmd.setup) begin
      trunc     <= avail > 16'(MAX_RUN);
      nemit     <= (avail > 16'(MAX_RUN)) ? RUN_W'(MAX_RUN) : avail[RUN_W-1:0];
      skip      <= avail - 16'(MAX_RUN);
      skip_step <= 48'(avail - 16'(MAX_RUN)) * 48'(sample_step);
      kcnt      <= '0;
    end
    if (cmd.advance) begin
      kcnt <= kcnt + 1'b1;
      if (cmd.incr) begin
        // Moving one step along the segment adds the per-step quotient and
        // remainder; a remainder overflow carries one into the quotient.
        for (int l = 0; l < LANES; l++) begin
          logic [32:0] rsum;
          rsum = {1'b0, lr[l]} + {1'b0, sr[l]};
          if (rsum >= {1'b0, span}) begin
            lr[l] <= 32'(rsum - {1'b0, span});
            lq[l] <= lq[l] + sq[l] + 1'b1;
          end else begin
            lr[l] <= rsum[31:0];
            lq[l] <= lq[l] + sq[l];
          end
        end
      end
    end
    if (cmd.latch_out) begin
      logic [33:0] v [LANES];
      for (int l = 0; l < LANES; l++) begin
        if (elapsed == 32'd0) begin
          v[l] = {{2{prev_pos[l][31]}}, prev_pos[l]};
        end else if (neg[l]) begin
          v[l] = {{2{prev_pos[l][31]}}, prev_pos[l]} - {1'b0, lq[l]};
        end else begin
          v[l] = {{2{prev_pos[l][31]}}, prev_pos[l]} + {1'b0, lq[l]};
        end
      end
      out_data.sample_time <= next_instant;
      out_data.val_a       <= v[0][31:0];
      out_data.val_b       <= v[1][31:0];
      out_data.val_c       <= v[2][31:0];
      out_data.val_d       <= v[3][31:0];
      out_data.run_end     <= last;
      out_data.truncated   <= trunc;
      out_data.all_done    <= (emitted_after == {1'b0, sample_count});
    end
  end

  assign sts.knot_start = knot_start;
  assign sts.started    = started;
  assign sts.no_avail   = (rem == 16'd0) || (next_instant >= knot_time);
  assign sts.step_zero  = (sample_step == 32'd0);
  assign sts.md_done    = md_done;
  assign sts.d_zero     = (elapsed == 32'd0);
  assign sts.last       = last;

endmodule

// ----- hw/rtl/ulir_ctrl.sv -----
// ----------------------------------------------------------------------------
// ulir_ctrl: sequencing controller of the resampler
// Steps through knot intake, sample count, per-lane setup divisions and the
// emission of each sample, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ulir_ctrl
  import ulir_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_RATIO, S_SETUP, S_CHECK, S_INIT, S_STEP, S_LATCH, S_EMIT
  } state_t;

  localparam lane_t LANE_LAST = lane_t'(LANES - 1);

  state_t state;
  logic   md_start;
  md_op_t md_op;
  lane_t  lane;
  logic   seeded;
  logic   live;

  assign live = !sts.knot_start && sts.started;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      md_start <= 1'b0;
      md_op    <= MD_RATIO;
      lane     <= '0;
      seeded   <= 1'b0;
    end else begin
      md_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (!live || sts.no_avail) begin
            state <= S_IDLE;
          end else if (sts.step_zero) begin
            state <= S_SETUP;
          end else begin
            md_op    <= MD_RATIO;
            md_start <= 1'b1;
            state    <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (sts.md_done) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          seeded <= 1'b0;
          state  <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.d_zero || seeded) begin
            state <= S_LATCH;
          end else begin
            lane     <= '0;
            md_op    <= MD_INIT;
            md_start <= 1'b1;
            state    <= S_INIT;
          end
        end
        S_INIT: begin
          if (sts.md_done) begin
            md_op    <= MD_STEP;
            md_start <= 1'b1;
            state    <= S_STEP;
          end
        end
        S_STEP: begin
          if (sts.md_done) begin
            if (lane == LANE_LAST) begin
              seeded <= 1'b1;
              state  <= S_LATCH;
            end else begin
              lane     <= lane_t'(lane + 1'b1);
              md_op    <= MD_INIT;
              md_start <= 1'b1;
              state    <= S_INIT;
            end
          end
        end
        S_LATCH: state <= S_EMIT;
        S_EMIT: begin
          if (!out_stall) begin
            state <= sts.last ? S_IDLE : S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    cmd             = '0;
    cmd.md_start    = md_start;
    cmd.md_op       = md_op;
    cmd.lane        = lane;
    cmd.incr        = seeded;
    cmd.start_apply = (state == S_CALC) && sts.knot_start;
    cmd.commit      = ((state == S_CALC) && live && sts.no_avail)
                    || ((state == S_EMIT) && !out_stall && sts.last);
    cmd.avail_rem   = (state == S_CALC) && live && !sts.no_avail && sts.step_zero;
    cmd.md_store    = ((state == S_RATIO) || (state == S_INIT) || (state == S_STEP))
                    && sts.md_done;
    cmd.setup       = (state == S_SETUP);
    cmd.latch_out   = (state == S_LATCH);
    cmd.advance     = (state == S_EMIT) && !out_stall;
  end

endmodule

// ----- hw/rtl/uniform_linear_interp_resampler.sv -----
// ----------------------------------------------------------------------------
// uniform_linear_interp_resampler: uniform-rate linear interpolation resampler
// Turns knots of a piecewise-linear four-lane trajectory into samples at the
// instants k * sample_step, linearly interpolated between knots.
// ----------------------------------------------------------------------------
// Timing for the user: the block takes one knot transaction at a time and
// holds in_stall high until every sample that knot causes has been taken. A
// start knot, a knot before any start, or a knot that covers no instant goes
// back to idle from the calculation state. Otherwise the sample count of the
// segment is found with a shared sequential multiply-divide unit (skipped
// when the step is zero). At the first sample of a segment that lies after
// the previous knot, that same unit runs two jobs per lane (eight jobs) to
// seed an exact quotient and remainder for each lane; every later sample of
// the segment then passes only through the check, latch and emit states,
// waiting out any output stall, since each step only adds the per-step
// quotient and remainder. Samples are exact: each value is the previous
// position plus the truncated fraction of the lane difference. At most 64
// samples come from one knot; the rest of a longer segment is skipped and
// counted, and that knot's samples carry the truncated flag. Configuration
// writes are always ready and must be made only while the block is idle.
// ----------------------------------------------------------------------------
module uniform_linear_interp_resampler
  import ulir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  // A knot transaction completes when the controller is idle and valid is up.
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ulir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ulir_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // No new knot is taken while a sample is offered.
  a_no_intake_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("knot accepted while a sample is pending");

  // The last sample of a knot ends its run of outputs.
  a_run_end_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.run_end) |=> !out_valid)
    else $error("sample offered after the run end");

  // Reaching the configured count can only happen on the last sample of a knot.
  a_done_on_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.all_done) |-> out_data.run_end)
    else $error("count reached before the run end");

endmodule
